// File: rtl/core/ulb_pkg.sv
// ulb_pkg: shared types and codes for the uart line buffer engine
// command and result word structs, operation codes, config register indexes
// no dependencies
package ulb_pkg;

    // operation codes carried in the command word
    localparam logic [2:0] OP_RX_BYTE  = 3'd0;
    localparam logic [2:0] OP_TX_TICK  = 3'd1;
    localparam logic [2:0] OP_WR_SEND  = 3'd2;
    localparam logic [2:0] OP_RD_RECV  = 3'd3;
    localparam logic [2:0] OP_CLR_RECV = 3'd4;
    localparam logic [2:0] OP_CLR_SEND = 3'd5;

    // config register indexes
    localparam int         CFG_IDX_W      = 1;
    localparam logic [0:0] CFG_END_CHAR   = 1'd0;
    localparam logic [0:0] CFG_EMPTY_CHAR = 1'd1;

    // config reset values
    localparam logic [7:0] END_CHAR_RST   = 8'd10;
    localparam logic [7:0] EMPTY_CHAR_RST = 8'd0;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic [4:0] entry_index;
    } t_cmd;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] read_byte;
        logic       rx_done;
        logic       tx_done;
    } t_result;

endpackage

// File: rtl/core/ulb_ram.sv
// ulb_ram: byte-wide buffer store, one write port and one registered read port
// depends on nothing
module ulb_ram #(
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ulb_seq.sv
// ulb_seq: sequencer of the line buffer engine, one byte compare/update per item
// drives both buffer stores, walks them for clears; uses ulb_pkg
module ulb_seq
    import ulb_pkg::*;
#(
    parameter int  RX_DEPTH = 32,
    parameter int  TX_DEPTH = 32,
    localparam int RX_AW    = $clog2(RX_DEPTH),
    localparam int TX_AW    = $clog2(TX_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_cmd             i_cmd,
    input  logic [7:0]       i_end_char,
    input  logic [7:0]       i_empty_char,
    output logic             o_busy,
    output logic             o_strobe,
    output t_result          o_result,
    output logic             o_rx_we,
    output logic [RX_AW-1:0] o_rx_waddr,
    output logic [7:0]       o_rx_wdata,
    output logic [RX_AW-1:0] o_rx_raddr,
    input  logic [7:0]       i_rx_rdata,
    output logic             o_tx_we,
    output logic [TX_AW-1:0] o_tx_waddr,
    output logic [7:0]       o_tx_wdata,
    output logic [TX_AW-1:0] o_tx_raddr,
    input  logic [7:0]       i_tx_rdata
);

    localparam int MAXD = (RX_DEPTH > TX_DEPTH) ? RX_DEPTH : TX_DEPTH;
    localparam int CW   = $clog2(MAXD);
    localparam int RPW  = $clog2(RX_DEPTH + 1);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CLEAR
    } t_state;

    t_state           r_state,   n_state;
    logic [CW-1:0]    r_cnt,     n_cnt;
    t_cmd             r_cmd,     n_cmd;
    logic [RPW-1:0]   r_rx_pos,  n_rx_pos;
    logic [TX_AW-1:0] r_tx_pos,  n_tx_pos;
    logic             r_rx_done, n_rx_done;
    logic             r_tx_done, n_tx_done;
    logic             r_strobe,  n_strobe;
    t_result          r_result,  n_result;

    logic [RX_AW-1:0] rx_slot;
    logic [TX_AW-1:0] tx_slot;
    logic             tx_last;
    logic             clr_rx;
    logic             clr_last;

    // wrapped buffer positions
    assign rx_slot = (r_rx_pos >= RPW'(RX_DEPTH)) ? '0 : RX_AW'(r_rx_pos);
    assign tx_slot = (32'(r_tx_pos) >= TX_DEPTH) ? '0 : r_tx_pos;
    assign tx_last = (tx_slot == TX_AW'(TX_DEPTH - 1));

    assign clr_rx   = (r_cmd.operation == OP_CLR_RECV);
    assign clr_last = clr_rx ? (r_cnt == CW'(RX_DEPTH - 1)) : (r_cnt == CW'(TX_DEPTH - 1));

    // reads are issued at the accept edge, data is used in the execute cycle
    assign o_rx_raddr = RX_AW'(i_cmd.entry_index);
    assign o_tx_raddr = tx_slot;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_cmd     = r_cmd;
        n_rx_pos  = r_rx_pos;
        n_tx_pos  = r_tx_pos;
        n_rx_done = r_rx_done;
        n_tx_done = r_tx_done;
        n_strobe  = 1'b0;
        n_result  = r_result;

        o_rx_we    = 1'b0;
        o_rx_waddr = RX_AW'(r_cnt);
        o_rx_wdata = i_empty_char;
        o_tx_we    = 1'b0;
        o_tx_waddr = TX_AW'(r_cnt);
        o_tx_wdata = i_empty_char;

        case (r_state)
            S_INIT: begin
                o_rx_we    = (32'(r_cnt) < RX_DEPTH);
                o_tx_we    = (32'(r_cnt) < TX_DEPTH);
                o_rx_wdata = EMPTY_CHAR_RST;
                o_tx_wdata = EMPTY_CHAR_RST;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CW'(MAXD - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_result = '0;
                case (r_cmd.operation)
                    OP_RX_BYTE: begin
                        if (r_cmd.data_byte != i_end_char) begin
                            o_rx_we    = 1'b1;
                            o_rx_waddr = rx_slot;
                            o_rx_wdata = r_cmd.data_byte;
                            n_rx_pos   = RPW'(rx_slot) + 1'b1;
                        end else begin
                            n_rx_done = 1'b1;
                            n_rx_pos  = '0;
                        end
                    end
                    OP_TX_TICK: begin
                        if (tx_last || (i_tx_rdata == i_end_char)) begin
                            n_result.tx_valid = 1'b1;
                            n_result.tx_byte  = i_tx_rdata;
                            n_tx_pos          = '0;
                            n_tx_done         = 1'b1;
                        end else if (i_tx_rdata != i_empty_char) begin
                            n_result.tx_valid = 1'b1;
                            n_result.tx_byte  = i_tx_rdata;
                            n_tx_pos          = tx_slot + 1'b1;
                        end else begin
                            n_tx_pos = tx_slot;
                        end
                    end
                    OP_WR_SEND: begin
                        o_tx_we    = (32'(r_cmd.entry_index) < TX_DEPTH);
                        o_tx_waddr = TX_AW'(r_cmd.entry_index);
                        o_tx_wdata = r_cmd.data_byte;
                    end
                    OP_RD_RECV: begin
                        if (32'(r_cmd.entry_index) < RX_DEPTH) begin
                            n_result.read_byte = i_rx_rdata;
                        end
                    end
                    OP_CLR_RECV, OP_CLR_SEND: begin
                        n_strobe = 1'b0;
                        n_result = r_result;
                        n_cnt    = '0;
                        n_state  = S_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end
            S_CLEAR: begin
                o_rx_we = clr_rx;
                o_tx_we = !clr_rx;
                n_cnt   = r_cnt + 1'b1;
                if (clr_last) begin
                    n_cnt    = '0;
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_result = '0;
                    if (clr_rx) begin
                        n_rx_done = 1'b0;
                    end else begin
                        n_tx_done = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_strobe) begin
            n_result.rx_done = n_rx_done;
            n_result.tx_done = n_tx_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_cnt     <= '0;
            r_rx_pos  <= '0;
            r_tx_pos  <= '0;
            r_rx_done <= 1'b0;
            r_tx_done <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rx_pos  <= n_rx_pos;
            r_tx_pos  <= n_tx_pos;
            r_rx_done <= n_rx_done;
            r_tx_done <= n_tx_done;
            r_strobe  <= n_strobe;
        end
        r_cmd    <= n_cmd;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// File: rtl/core/uart_line_buffer_engine.sv
// uart_line_buffer_engine: top level of the receive/send line buffers beside a uart
// holds the config registers, both buffer stores and the sequencer
// depends on ulb_pkg, ulb_ram, ulb_seq
//
// channel   direction  handshake                     word
// -------   ---------  ----------------------------  -------------------------
// command   in         start high while busy low     i_cmd (t_cmd)
// result    out        o_strobe, one cycle, no stall o_result (t_result)
// config    in         i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
// a command word is handled in order: the accept edge issues the buffer read,
// the execute cycle does the single compare and read-modify-write, and the
// result strobe overlaps the next accept, so a new word can follow once the
// execute cycle is over; clear receive / clear send walk the store one entry
// a cycle, with busy high from the execute cycle to the end of the walk
// after reset both stores are walked to the reset empty value, with busy
// high throughout; config writes are taken at any time
// the receiver cannot stall, each result stands for exactly one cycle
module uart_line_buffer_engine
    import ulb_pkg::*;
#(
    parameter int RX_DEPTH = 32,
    parameter int TX_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  t_cmd                 i_cmd,
    // result channel
    output logic                 o_strobe,
    output t_result              o_result,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);

    // config registers
    logic [7:0] r_end_char;
    logic [7:0] r_empty_char;

    // buffer store ports
    logic             rx_we;
    logic [RX_AW-1:0] rx_waddr;
    logic [7:0]       rx_wdata;
    logic [RX_AW-1:0] rx_raddr;
    logic [7:0]       rx_rdata;
    logic             tx_we;
    logic [TX_AW-1:0] tx_waddr;
    logic [7:0]       tx_wdata;
    logic [TX_AW-1:0] tx_raddr;
    logic [7:0]       tx_rdata;

    // config port is always ready, writes are registered
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_char   <= END_CHAR_RST;
            r_empty_char <= EMPTY_CHAR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_END_CHAR:   r_end_char   <= i_cfg_data;
                CFG_EMPTY_CHAR: r_empty_char <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // receive line store
    ulb_ram #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (rx_wdata),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    // send line store
    ulb_ram #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (tx_wdata),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    // sequencer: positions, done flags, compare and update, clear walks
    ulb_seq #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (i_cmd),
        .i_end_char   (r_end_char),
        .i_empty_char (r_empty_char),
        .o_busy       (busy),
        .o_strobe     (o_strobe),
        .o_result     (o_result),
        .o_rx_we      (rx_we),
        .o_rx_waddr   (rx_waddr),
        .o_rx_wdata   (rx_wdata),
        .o_rx_raddr   (rx_raddr),
        .i_rx_rdata   (rx_rdata),
        .o_tx_we      (tx_we),
        .o_tx_waddr   (tx_waddr),
        .o_tx_wdata   (tx_wdata),
        .o_tx_raddr   (tx_raddr),
        .i_tx_rdata   (tx_rdata)
    );

    // an accepted word keeps the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    // results are never back to back, every word needs an execute cycle
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe on two cycles in a row");

    // a result follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a word in flight");

    // no transmit byte without tx_valid
    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.tx_valid) |-> (o_result.tx_byte == 8'd0))
        else $error("tx byte set without tx valid");

endmodule
